FILE: rtl/core/sba_pkg.sv
// shared constants, codes and control structs of the slab block allocator
package sba_pkg;

  localparam int MAX_SLABS_DEF  = 16;
  localparam int MAX_BLOCKS_DEF = 256;

  localparam int OP_W     = 2;
  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 32;
  localparam int STAT_W   = 3;
  localparam int TOTAL_W  = 13;
  localparam int BS_W     = 16;
  localparam int HDR_W    = 8;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [OP_W-1:0] OP_GROW  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_OOM      = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADLEN   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STAT_W-1:0] ST_OVERFREE = 3'd5;

  localparam logic [BS_W-1:0]    BS_RST    = 16'd8;
  localparam logic [HDR_W-1:0]   HDR_RST   = 8'd24;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // register index, taken from the word address of the config port
  localparam logic REG_BLOCK_SIZE   = 1'b0;
  localparam logic REG_HEADER_BYTES = 1'b1;

  typedef struct packed {
    logic              accept;
    logic              div_start;
    logic              q_cap;
    logic              g_mul;
    logic              g_base;
    logic              fill_wr;
    logic              g_commit;
    logic              idx_dec;
    logic              a_pop;
    logic              a_rd;
    logic              f_mul;
    logic              f_push;
    logic              st_load;
    logic [STAT_W-1:0] st_code;
    logic              out_load;
  } sba_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            bad_len;
    logic            no_slabs;
    logic            addr_zero;
    logic            div_done;
    logic            q_zero;
    logic            fill_last;
    logic            free_nz;
    logic            idx_zero;
    logic            in_range;
    logic            over;
    logic            out_free;
  } sba_flags_t;

endpackage

FILE: rtl/core/sba_if.sv
// valid/ready channel interfaces for allocator requests and results
interface sba_in_if import sba_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [ADDR_W-1:0]   address;
  logic [LEN_W-1:0]    length;

  modport source (output valid, operation, address, length, input ready);
  modport sink   (input valid, operation, address, length, output ready);
endinterface

interface sba_out_if import sba_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [ADDR_W-1:0]   block_address;
  logic [TOTAL_W-1:0]  free_total;

  modport source (output valid, status, block_address, free_total, input ready);
  modport sink   (input valid, status, block_address, free_total, output ready);
endinterface

FILE: rtl/core/sba_div.sv
// restoring divider, one quotient bit per cycle, for the grow block count
module sba_div import sba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [LEN_W-1:0]  dividend,
  input  logic [BS_W-1:0]   divisor,
  output logic              done,
  output logic [LEN_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(LEN_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] q_r, q_nxt;
  logic [BS_W-1:0]  rem_r, rem_nxt;
  logic [BS_W:0]    trial;

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    trial   = {rem_r, q_r[LEN_W-1]};
    if (start) begin
      cnt_nxt = CNT_W'(LEN_W);
      q_nxt   = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = BS_W'(trial - {1'b0, divisor});
        q_nxt   = {q_r[LEN_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[BS_W-1:0];
        q_nxt   = {q_r[LEN_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = (cnt_r == '0);
  assign quotient = q_r;

endmodule

FILE: rtl/core/sba_ctrl.sv
// sequencing state machine of the slab block allocator
module sba_ctrl import sba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  sba_flags_t flags,
  output sba_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_GCHK  = 4'd3;
  localparam logic [3:0] S_GMUL  = 4'd4;
  localparam logic [3:0] S_GADD  = 4'd5;
  localparam logic [3:0] S_GFILL = 4'd6;
  localparam logic [3:0] S_GCOM  = 4'd7;
  localparam logic [3:0] S_ASCAN = 4'd8;
  localparam logic [3:0] S_APOP  = 4'd9;
  localparam logic [3:0] S_ARD   = 4'd10;
  localparam logic [3:0] S_FMUL  = 4'd11;
  localparam logic [3:0] S_FCMP  = 4'd12;
  localparam logic [3:0] S_FPUSH = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;

  logic [3:0] state_r, state_nxt;

  // no transfer is taken while reset is held
  assign in_ready = rst_n && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && rst_n) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_FIN;
        cmd.st_load = 1'b1;
        cmd.st_code = ST_OK;
        unique case (flags.op)
          OP_GROW: begin
            if (flags.full) begin
              cmd.st_code = ST_FULL;
            end else if (flags.bad_len) begin
              cmd.st_code = ST_BADLEN;
            end else begin
              cmd.st_load   = 1'b0;
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          OP_ALLOC: begin
            if (flags.no_slabs) begin
              cmd.st_code = ST_OOM;
            end else begin
              cmd.st_load = 1'b0;
              state_nxt   = S_ASCAN;
            end
          end
          OP_FREE: begin
            if (flags.addr_zero) begin
              cmd.st_code = ST_OK;
            end else if (flags.no_slabs) begin
              cmd.st_code = ST_NOTFOUND;
            end else begin
              cmd.st_load = 1'b0;
              state_nxt   = S_FMUL;
            end
          end
          default: cmd.st_code = ST_OK;
        endcase
      end
      S_DIV: begin
        if (flags.div_done) state_nxt = S_GCHK;
      end
      S_GCHK: begin
        if (flags.q_zero) begin
          cmd.st_load = 1'b1;
          cmd.st_code = ST_BADLEN;
          state_nxt   = S_FIN;
        end else begin
          cmd.q_cap = 1'b1;
          state_nxt = S_GMUL;
        end
      end
      S_GMUL: begin
        cmd.g_mul = 1'b1;
        state_nxt = S_GADD;
      end
      S_GADD: begin
        cmd.g_base = 1'b1;
        state_nxt  = S_GFILL;
      end
      S_GFILL: begin
        cmd.fill_wr = 1'b1;
        if (flags.fill_last) state_nxt = S_GCOM;
      end
      S_GCOM: begin
        cmd.g_commit = 1'b1;
        cmd.st_load  = 1'b1;
        cmd.st_code  = ST_OK;
        state_nxt    = S_FIN;
      end
      S_ASCAN: begin
        if (flags.free_nz) begin
          state_nxt = S_APOP;
        end else if (flags.idx_zero) begin
          cmd.st_load = 1'b1;
          cmd.st_code = ST_OOM;
          state_nxt   = S_FIN;
        end else begin
          cmd.idx_dec = 1'b1;
        end
      end
      S_APOP: begin
        cmd.a_pop = 1'b1;
        state_nxt = S_ARD;
      end
      S_ARD: begin
        cmd.a_rd    = 1'b1;
        cmd.st_load = 1'b1;
        cmd.st_code = ST_OK;
        state_nxt   = S_FIN;
      end
      S_FMUL: begin
        cmd.f_mul = 1'b1;
        state_nxt = S_FCMP;
      end
      S_FCMP: begin
        if (flags.in_range) begin
          if (flags.over) begin
            cmd.st_load = 1'b1;
            cmd.st_code = ST_OVERFREE;
            state_nxt   = S_FIN;
          end else begin
            state_nxt = S_FPUSH;
          end
        end else if (flags.idx_zero) begin
          cmd.st_load = 1'b1;
          cmd.st_code = ST_NOTFOUND;
          state_nxt   = S_FIN;
        end else begin
          cmd.idx_dec = 1'b1;
          state_nxt   = S_FMUL;
        end
      end
      S_FPUSH: begin
        cmd.f_push  = 1'b1;
        cmd.st_load = 1'b1;
        cmd.st_code = ST_OK;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (flags.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/sba_dp.sv
// allocator datapath: slab table, free-block stack memory, arithmetic and result register
module sba_dp import sba_pkg::*; #(
  parameter int MAX_SLABS  = MAX_SLABS_DEF,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sba_cmd_t            cmd,
  output sba_flags_t          flags,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [ADDR_W-1:0]   in_address,
  input  logic [LEN_W-1:0]    in_length,
  input  logic [BS_W-1:0]     block_size,
  input  logic [HDR_W-1:0]    header_bytes,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [STAT_W-1:0]   out_status,
  output logic [ADDR_W-1:0]   out_block_address,
  output logic [TOTAL_W-1:0]  out_free_total
);

  localparam int CW    = $clog2(MAX_BLOCKS + 1);
  localparam int KW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int SW    = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
  localparam int NW    = $clog2(MAX_SLABS + 1);
  localparam int DEPTH = MAX_SLABS * MAX_BLOCKS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUMW  = $clog2(DEPTH + 1);
  localparam int SUMX  = (SUMW > TOTAL_W) ? SUMW : TOTAL_W;
  localparam int PW    = BS_W + CW;
  localparam int HW    = ((PW > ADDR_W) ? PW : ADDR_W) + 2;

  function automatic logic [AW-1:0] slot(input logic [SW-1:0] s, input logic [KW-1:0] k);
    slot = AW'(s) * AW'(MAX_BLOCKS) + AW'(k);
  endfunction

  // item registers
  logic [OP_W-1:0]   op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [LEN_W-1:0]  len_r;

  // slab table
  logic [ADDR_W-1:0] rbase  [MAX_SLABS];
  logic [CW-1:0]     rblk   [MAX_SLABS];
  logic [CW-1:0]     rfree  [MAX_SLABS];
  logic [ADDR_W-1:0] stack  [DEPTH];

  logic [NW-1:0]     slabs_r;
  logic [SUMW-1:0]   sum_r;
  logic [SW-1:0]     idx_r;
  logic [KW-1:0]     k_r;
  logic [CW-1:0]     cnt_r;
  logic [ADDR_W-1:0] a_r;
  logic [PW-1:0]     prod_r;
  logic [ADDR_W-1:0] base_r;
  logic [ADDR_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] blk_r;
  logic [STAT_W-1:0] status_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [ADDR_W-1:0] out_block_r;
  logic [TOTAL_W-1:0] out_total_r;

  logic [NW-1:0]     slabs_m1;
  logic [CW-1:0]     free_cur, blk_cur, free_m1, mul_a;
  logic [HW-1:0]     hi;
  logic              div_done;
  logic [LEN_W-1:0]  quot;
  logic [LEN_W-1:0]  dividend;
  logic              mem_we;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [ADDR_W-1:0] mem_wd;
  logic [SUMX-1:0]   sum_x;

  assign slabs_m1 = slabs_r - NW'(1);
  assign free_cur = rfree[idx_r];
  assign blk_cur  = rblk[idx_r];
  assign free_m1  = free_cur - CW'(1);
  assign dividend = len_r - LEN_W'(header_bytes);
  assign hi       = HW'(base_r) + HW'(header_bytes) + HW'(prod_r);
  assign mul_a    = cmd.f_mul ? blk_cur : (cnt_r - CW'(1));
  assign sum_x    = SUMX'(sum_r);

  sba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (block_size),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    flags.op        = op_r;
    flags.full      = (slabs_r == NW'(MAX_SLABS));
    flags.bad_len   = (block_size == '0) || (len_r <= LEN_W'(header_bytes));
    flags.no_slabs  = (slabs_r == '0);
    flags.addr_zero = (addr_r == '0);
    flags.div_done  = div_done;
    flags.q_zero    = (quot == '0);
    flags.fill_last = (CW'(k_r) == (cnt_r - CW'(1)));
    flags.free_nz   = (free_cur != '0);
    flags.idx_zero  = (idx_r == '0);
    flags.in_range  = (addr_r > base_r) && (HW'(addr_r) < hi);
    flags.over      = (free_cur >= blk_cur) || (free_cur >= CW'(MAX_BLOCKS));
    flags.out_free  = !out_valid_r || out_ready;
  end

  // stack memory ports
  always_comb begin
    mem_we = cmd.fill_wr || cmd.f_push;
    mem_wa = cmd.fill_wr ? slot(idx_r, k_r) : slot(idx_r, free_cur[KW-1:0]);
    mem_wd = cmd.fill_wr ? a_r : addr_r;
    mem_ra = slot(idx_r, free_m1[KW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (mem_we) stack[mem_wa] <= mem_wd;
    if (cmd.a_pop) rd_data_r <= stack[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.g_commit) begin
      rbase[idx_r] <= addr_r;
      rblk[idx_r]  <= cnt_r;
      rfree[idx_r] <= cnt_r;
    end else if (cmd.a_pop) begin
      rfree[idx_r] <= free_m1;
    end else if (cmd.f_push) begin
      rfree[idx_r] <= free_cur + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_operation;
      addr_r <= in_address;
      len_r  <= in_length;
      blk_r  <= '0;
      idx_r  <= (in_operation == OP_GROW) ? slabs_r[SW-1:0] : slabs_m1[SW-1:0];
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - SW'(1);
    end
    if (cmd.q_cap) begin
      cnt_r <= (quot > LEN_W'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : quot[CW-1:0];
    end
    if (cmd.g_mul || cmd.f_mul) prod_r <= PW'(mul_a) * PW'(block_size);
    if (cmd.f_mul) base_r <= rbase[idx_r];
    // first entry holds the highest block so the lowest one sits on top
    if (cmd.g_base) begin
      a_r <= addr_r + ADDR_W'(header_bytes) + ADDR_W'(prod_r);
      k_r <= '0;
    end else if (cmd.fill_wr) begin
      a_r <= a_r - ADDR_W'(block_size);
      k_r <= k_r + KW'(1);
    end
    if (cmd.a_rd) blk_r <= rd_data_r;
    if (cmd.st_load) status_r <= cmd.st_code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slabs_r <= '0;
      sum_r   <= '0;
    end else begin
      if (cmd.g_commit) begin
        slabs_r <= slabs_r + NW'(1);
        sum_r   <= sum_r + SUMW'(cnt_r);
      end else if (cmd.a_pop) begin
        sum_r <= sum_r - SUMW'(1);
      end else if (cmd.f_push) begin
        sum_r <= sum_r + SUMW'(1);
      end
    end
  end

  // result register, freed by the transfer on the result channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_block_r  <= blk_r;
      out_total_r  <= (sum_x > SUMX'(TOTAL_MAX)) ? TOTAL_MAX : sum_x[TOTAL_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_address = out_block_r;
  assign out_free_total    = out_total_r;

endmodule

FILE: rtl/core/slab_block_allocator.sv
// Slab block allocator: fixed-size blocks handed out of up to MAX_SLABS registered regions.
// One request is worked at a time. A grow divides the length past the header by the block
// size in the bit-serial divider, then carves its blocks one by one through the single write
// port of the free-block stack memory. An alloc checks slabs from the newest down, a free
// checks them from the newest down as well, each check needing a multiply then an address
// compare. The stack memory is not cleared after reset; entries are only read once written.
// The result register lets a new request be taken while the last result waits.
module slab_block_allocator import sba_pkg::*; #(
  parameter int MAX_SLABS           = MAX_SLABS_DEF,
  parameter int MAX_BLOCKS_PER_SLAB = MAX_BLOCKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  sba_in_if.sink             in_ch,
  sba_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [BS_W-1:0]  bs_r;
  logic [HDR_W-1:0] hdr_r;
  logic             reg_sel;
  logic             cfg_wr;
  sba_cmd_t         cmd;
  sba_flags_t       flags;

  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r  <= BS_RST;
      hdr_r <= HDR_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_BLOCK_SIZE:   bs_r  <= pwdata[BS_W-1:0];
        REG_HEADER_BYTES: hdr_r <= pwdata[HDR_W-1:0];
        default:          bs_r  <= bs_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BLOCK_SIZE:   prdata = PDATA_W'(bs_r);
      REG_HEADER_BYTES: prdata = PDATA_W'(hdr_r);
      default:          prdata = '0;
    endcase
  end

  sba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .flags    (flags),
    .cmd      (cmd)
  );

  sba_dp #(
    .MAX_SLABS  (MAX_SLABS),
    .MAX_BLOCKS (MAX_BLOCKS_PER_SLAB)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .flags             (flags),
    .in_operation      (in_ch.operation),
    .in_address        (in_ch.address),
    .in_length         (in_ch.length),
    .block_size        (bs_r),
    .header_bytes      (hdr_r),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_status        (out_ch.status),
    .out_block_address (out_ch.block_address),
    .out_free_total    (out_ch.free_total)
  );

endmodule

FILE: verif/slab_block_allocator_tb.sv
// self-checking testbench for the slab block allocator: directed and random requests
module slab_block_allocator_tb;
  import sba_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int N_SLABS   = MAX_SLABS_DEF;
  localparam int N_BLOCKS  = MAX_BLOCKS_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam logic [PADDR_W-1:0] ADDR_BLOCK_SIZE   = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_HEADER_BYTES = 3'd4;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [ADDR_W-1:0]  block_address;
    logic [TOTAL_W-1:0] free_total;
  } alloc_result_t;

  class slab_pool_model;
    bit [BS_W-1:0]    blk_size;
    bit [HDR_W-1:0]   hdr_len;
    int unsigned      slabs_used;
    bit [31:0]        base_of[N_SLABS];
    int unsigned      blocks_of[N_SLABS];
    int unsigned      free_of[N_SLABS];
    bit [31:0]        stack_mem[N_SLABS*N_BLOCKS];
    int unsigned      free_count;
    bit [31:0]        live_blocks[$];
    alloc_result_t    awaited[$];
    int               errors;

    function new();
      blk_size = BS_RST;
      hdr_len = HDR_RST;
      slabs_used = 0;
      free_count = 0;
      errors = 0;
    endfunction

    function bit [STAT_W-1:0] grow(bit [31:0] base, bit [31:0] len);
      longint unsigned cnt;
      longint unsigned a;
      int unsigned s;
      s = slabs_used;
      if (s >= N_SLABS) return ST_FULL;
      if (blk_size == 0 || longint'(len) <= longint'(hdr_len)) return ST_BADLEN;
      cnt = (longint'(len) - hdr_len) / blk_size;
      if (cnt == 0) return ST_BADLEN;
      if (cnt > N_BLOCKS) cnt = N_BLOCKS;
      base_of[s] = base;
      blocks_of[s] = 32'(cnt);
      free_of[s] = 32'(cnt);
      for (longint unsigned k = 0; k < cnt; k++) begin
        a = longint'(base) + hdr_len + (cnt - 1 - k) * blk_size;
        stack_mem[s*N_BLOCKS + k] = a[31:0];
      end
      slabs_used = s + 1;
      free_count += 32'(cnt);
      return ST_OK;
    endfunction

    function bit [STAT_W-1:0] take(output bit [31:0] blk);
      blk = '0;
      for (int i = slabs_used - 1; i >= 0; i--) begin
        if (free_of[i] > 0) begin
          free_of[i]--;
          blk = stack_mem[i*N_BLOCKS + free_of[i]];
          free_count--;
          live_blocks.push_back(blk);
          return ST_OK;
        end
      end
      return ST_OOM;
    endfunction

    function bit [STAT_W-1:0] give(bit [31:0] a);
      longint unsigned lo, hi;
      if (a == 0) return ST_OK;
      for (int i = slabs_used - 1; i >= 0; i--) begin
        lo = base_of[i];
        hi = lo + hdr_len + longint'(blk_size) * blocks_of[i];
        if (longint'(a) > lo && longint'(a) < hi) begin
          if (free_of[i] >= blocks_of[i] || free_of[i] >= N_BLOCKS) return ST_OVERFREE;
          stack_mem[i*N_BLOCKS + free_of[i]] = a;
          free_of[i]++;
          free_count++;
          return ST_OK;
        end
      end
      return ST_NOTFOUND;
    endfunction

    function void note_request(bit [OP_W-1:0] op, bit [31:0] a, bit [31:0] len);
      alloc_result_t r;
      bit [31:0] blk;
      r.status = ST_OK;
      r.block_address = '0;
      case (op)
        OP_GROW:  r.status = grow(a, len);
        OP_ALLOC: begin
          r.status = take(blk);
          r.block_address = blk;
        end
        OP_FREE:  r.status = give(a);
        default:  ;
      endcase
      r.free_total = (free_count > 8191) ? 13'd8191 : free_count[TOTAL_W-1:0];
      awaited.push_back(r);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
    endtask

    task check_result(logic [STAT_W-1:0] st, logic [ADDR_W-1:0] blk, logic [TOTAL_W-1:0] tot);
      alloc_result_t w;
      if (awaited.size() == 0) begin
        report("unexpected result status", st, 0);
        return;
      end
      w = awaited.pop_front();
      if (st !== w.status) report("status", st, w.status);
      if (blk !== w.block_address) report("block_address", blk, w.block_address);
      if (tot !== w.free_total) report("free_total", tot, w.free_total);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  sba_in_if  in_ch();
  sba_out_if out_ch();

  slab_block_allocator DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  slab_pool_model pool = new();
  int in_xfers = 0;
  int idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.address = '0;
    in_ch.length = '0;
    out_ch.ready = 1'b0;
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        pool.note_request(in_ch.operation, in_ch.address, in_ch.length);
        in_xfers++;
      end
      if (out_ch.valid && out_ch.ready)
        pool.check_result(out_ch.status, out_ch.block_address, out_ch.free_total);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // receiver: bursts of ready with random stalls
  initial begin
    int run, g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ch.ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 20);
      repeat (run - 1) @(negedge clk);
      g = gap_len();
      if (g > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  // called at a falling edge; returns at a falling edge
  task send_request(logic [OP_W-1:0] op, logic [31:0] a, logic [31:0] len);
    int c, g;
    c = in_xfers;
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.address <= a;
    in_ch.length <= len;
    do @(negedge clk); while (in_xfers == c);
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pool.awaited.size() != 0) @(negedge clk);
  endtask

  task write_reg(logic [PADDR_W-1:0] a, logic [PDATA_W-1:0] d);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= a;
    pwdata <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task set_geometry(bit [BS_W-1:0] bs, bit [HDR_W-1:0] hdr);
    drain_results();
    // every result has been drained, so no grow is still carving when the registers change
    repeat (20) @(negedge clk);
    write_reg(ADDR_BLOCK_SIZE, {16'd0, bs});
    write_reg(ADDR_HEADER_BYTES, {24'd0, hdr});
    pool.blk_size = bs;
    pool.hdr_len = hdr;
  endtask

  task random_request();
    int r, k, s;
    longint unsigned len;
    bit [31:0] a;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      k = $urandom_range(0, 9);
      if (k < 6)
        len = longint'(pool.hdr_len) + longint'(pool.blk_size) * $urandom_range(1, 16)
              + $urandom_range(0, pool.blk_size - 1);
      else if (k < 8) len = $urandom();
      else len = $urandom_range(0, pool.hdr_len);
      a = ($urandom_range(0, 4) == 0) ? $urandom() : {8'($urandom_range(0, 255)), 24'd0};
      send_request(OP_GROW, a, len[31:0]);
    end else if (r < 52) begin
      send_request(OP_ALLOC, $urandom(), $urandom());
    end else if (r < 97) begin
      k = $urandom_range(0, 99);
      if (k < 60 && pool.live_blocks.size() > 0) begin
        s = $urandom_range(0, pool.live_blocks.size() - 1);
        a = pool.live_blocks[s];
        pool.live_blocks.delete(s);
      end else if (k < 72 && pool.live_blocks.size() > 0) begin
        // free a live block but keep it in the list, so it may be freed again later
        a = pool.live_blocks[$urandom_range(0, pool.live_blocks.size() - 1)];
      end else if (k < 78) begin
        a = '0;
      end else if (k < 92 && pool.slabs_used > 0) begin
        s = $urandom_range(0, pool.slabs_used - 1);
        a = pool.base_of[s] + $urandom_range(0, 600);
      end else begin
        a = $urandom();
      end
      send_request(OP_FREE, a, $urandom());
    end else begin
      send_request(OP_NONE, $urandom(), $urandom());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at reset geometry
    send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_FREE, 32'h0, 32'h0);
    send_request(OP_FREE, 32'h1234_5678, 32'h0);
    send_request(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_GROW, 32'h1000, 32'd24);
    send_request(OP_GROW, 32'h1000, 32'd31);
    send_request(OP_GROW, 32'h1000, 32'd48);
    send_request(OP_ALLOC, 32'h0, 32'h0);
    send_request(OP_ALLOC, 32'h0, 32'h0);
    send_request(OP_ALLOC, 32'h0, 32'h0);
    send_request(OP_ALLOC, 32'h0, 32'h0);
    send_request(OP_FREE, 32'h1018, 32'h0);
    send_request(OP_FREE, 32'h1020, 32'h0);
    send_request(OP_FREE, 32'h1028, 32'h0);
    send_request(OP_FREE, 32'h1028, 32'h0);
    send_request(OP_FREE, 32'h1000, 32'h0);
    send_request(OP_FREE, 32'h1030, 32'h0);
    send_request(OP_GROW, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, 32'h0, 32'h0);
    send_request(OP_ALLOC, 32'h0, 32'h0);
    send_request(OP_FREE, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_FREE, 32'h0000_0008, 32'h0);
    pool.live_blocks.delete();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ;
        1: set_geometry(16'd1, 8'd0);
        2: set_geometry(16'd65535, 8'd255);
        5: set_geometry(BS_RST, HDR_RST);
        default: set_geometry(16'($urandom_range(1, 65535)), 8'($urandom_range(0, 255)));
      endcase
      for (int n = 0; n < 240; n++) begin
        if (ph == 3 && n == 120) drain_results();
        random_request();
      end
    end

    drain_results();
    repeat (50) @(negedge clk);
    if (pool.errors == 0 && pool.awaited.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
